// File: rtl/ppu_pkg.sv
// Shared types and constants for the point projection unit.
// No dependencies; rtl/point_projection_unit.sv and the test files import this package.
package ppu_pkg;

	// Quotient bits developed by the perspective divider, one per stage.
	localparam int unsigned QBITS = 42;

	// Configuration register indexes.
	localparam logic [2:0] REG_MODE    = 3'd0;
	localparam logic [2:0] REG_TAN     = 3'd1;
	localparam logic [2:0] REG_SLOPE_X = 3'd2;
	localparam logic [2:0] REG_SLOPE_Y = 3'd3;
	localparam logic [2:0] REG_SCALE_X = 3'd4;
	localparam logic [2:0] REG_SCALE_Y = 3'd5;
	localparam logic [2:0] REG_CENTER_X = 3'd6;
	localparam logic [2:0] REG_CENTER_Y = 3'd7;

	// Magnitude clamp of a perspective term (2^40).
	localparam logic [41:0] TERM_LIMIT = 42'h100_0000_0000;

	// Products taken right after the input.
	typedef struct packed {
		logic        [62:0] n_x;
		logic        [62:0] n_y;
		logic        [61:0] den;
		logic signed [63:0] sh_x;
		logic signed [63:0] sh_y;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic               neg_x;
		logic               neg_y;
		logic               nz_x;
		logic               nz_y;
		logic               zdiv;
	} prod_t;

	// One divider stage: both perspective lanes plus the parallel terms riding along.
	typedef struct packed {
		logic        [61:0] den;
		logic        [61:0] rem_x;
		logic        [61:0] rem_y;
		logic        [41:0] num_x;
		logic        [41:0] num_y;
		logic        [41:0] quo_x;
		logic        [41:0] quo_y;
		logic               ovf_x;
		logic               ovf_y;
		logic               neg_x;
		logic               neg_y;
		logic               nz_x;
		logic               nz_y;
		logic               zdiv;
		logic signed [48:0] p_x;
		logic signed [48:0] p_y;
		logic signed [66:0] par_x;
		logic signed [66:0] par_y;
		logic signed [49:0] lo_x;
		logic signed [49:0] lo_y;
	} dv_t;

endpackage

// File: rtl/ppu_point_if.sv
// Input channel of the point projection unit: one camera-space point per beat.
// Depends on nothing.
interface ppu_point_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] point_x;
	logic signed [31:0] point_y;
	logic signed [31:0] point_z;

	modport source (output valid, output point_x, output point_y, output point_z, input ready);
	modport sink (input valid, input point_x, input point_y, input point_z, output ready);
endinterface

// File: rtl/ppu_screen_if.sv
// Output channel of the point projection unit: one screen position per beat.
// Depends on nothing.
interface ppu_screen_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] screen_x;
	logic signed [31:0] screen_y;
	logic               range_flag;

	modport source (output valid, output screen_x, output screen_y, output range_flag,
		input ready);
	modport sink (input valid, input screen_x, input screen_y, input range_flag,
		output ready);
endinterface

// File: rtl/point_projection_unit.sv
// Point projection unit top level: perspective and oblique parallel projection in Q16.16.
// Depends on ppu_pkg, ppu_point_if and ppu_screen_if.
//
//  channel   dir  beat contents                          handshake
//  point     in   point_x, point_y, point_z (s32 each)    valid / ready
//  screen    out  screen_x, screen_y (s32), range_flag    valid / ready
//  cfg       in   cfg_index (3b), cfg_data (32b)          cfg_we, no back-pressure
//
// One point enters per cycle unless the pipe holds; beats pass stages 1 and 2, the divider and the output register.
// The depth is set by the perspective divider, which develops one quotient bit per stage.
// Everything advances together: when the output register holds an untaken beat, the whole
// pipe holds and point.ready drops, so nothing is lost or repeated.
// arst_n clears the valid bits and loads the register reset values; data registers
// are not reset.
module point_projection_unit
	import ppu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	ppu_point_if.sink   point,
	ppu_screen_if.source screen
);

	// ---------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------
	logic               mode_q;
	logic [30:0]        tan_q;
	logic signed [31:0] slope_x_q, slope_y_q, scale_x_q, scale_y_q, center_x_q, center_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= 1'b1;
			tan_q      <= 31'd65536;
			slope_x_q  <= '0;
			slope_y_q  <= '0;
			scale_x_q  <= 32'sd65536;
			scale_y_q  <= 32'sd65536;
			center_x_q <= '0;
			center_y_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MODE:     mode_q     <= cfg_data[0];
				REG_TAN:      tan_q      <= cfg_data[30:0];
				REG_SLOPE_X:  slope_x_q  <= cfg_data;
				REG_SLOPE_Y:  slope_y_q  <= cfg_data;
				REG_SCALE_X:  scale_x_q  <= cfg_data;
				REG_SCALE_Y:  scale_y_q  <= cfg_data;
				REG_CENTER_X: center_x_q <= cfg_data;
				REG_CENTER_Y: center_y_q <= cfg_data;
				default:      ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Flow control: one enable for the whole pipe
	// ---------------------------------------------------------------
	logic             adv;
	logic             v_s1;
	logic [QBITS:0]   vld_s;     // vld_s[0] is stage 2, vld_s[k] follows divider step k
	logic             out_valid_q;

	assign adv         = !out_valid_q || screen.ready;
	assign point.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			vld_s       <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= point.valid;
			vld_s       <= {vld_s[QBITS-1:0], v_s1};
			out_valid_q <= vld_s[QBITS];
		end
	end

	// ---------------------------------------------------------------
	// Stage 1: magnitudes and all input products
	// ---------------------------------------------------------------
	logic [31:0] ax, ay, az, acx;
	logic [63:0] nx_full, ny_full;
	logic [62:0] den_full;
	prod_t       p1;
	prod_t       st_s1;

	always_comb begin
		ax  = point.point_x[31] ? 32'(32'd0 - point.point_x) : point.point_x;
		ay  = point.point_y[31] ? 32'(32'd0 - point.point_y) : point.point_y;
		az  = point.point_z[31] ? 32'(32'd0 - point.point_z) : point.point_z;
		acx = center_x_q[31] ? 32'(32'd0 - center_x_q) : center_x_q;

		nx_full  = ax * acx;
		ny_full  = ay * acx;
		den_full = az * tan_q;

		p1.n_x  = nx_full[62:0];
		p1.n_y  = ny_full[62:0];
		p1.den  = den_full[61:0];
		p1.sh_x = point.point_z * slope_x_q;
		p1.sh_y = point.point_z * slope_y_q;
		p1.x    = point.point_x;
		p1.y    = point.point_y;
		p1.zdiv = (point.point_z == 32'sd0) || (tan_q == 31'd0);
		// y is projected as -y: its sign bit is "y positive"
		p1.neg_x = (point.point_x[31] ^ center_x_q[31]) ^ (!p1.zdiv && point.point_z[31]);
		p1.neg_y = ((point.point_y != 32'sd0) && !point.point_y[31]) ^ center_x_q[31]
			^ (!p1.zdiv && point.point_z[31]);
		p1.nz_x = (point.point_x != 32'sd0) && (center_x_q != 32'sd0);
		p1.nz_y = (point.point_y != 32'sd0) && (center_x_q != 32'sd0);
	end

	always_ff @(posedge clk) begin
		if (adv) st_s1 <= p1;
	end

	// ---------------------------------------------------------------
	// Stage 2: divider setup (overflow precheck) and oblique shear add
	// ---------------------------------------------------------------
	dv_t         step_s [0:QBITS];
	dv_t         p2;
	logic [61:0] top_x, top_y;

	always_comb begin
		// dividend is n * 2^16; its bits above the quotient window are n[62:26]
		top_x = {25'd0, st_s1.n_x[62:26]};
		top_y = {25'd0, st_s1.n_y[62:26]};
		p2       = '0;
		p2.den   = st_s1.den;
		p2.ovf_x = top_x >= st_s1.den;
		p2.ovf_y = top_y >= st_s1.den;
		p2.rem_x = p2.ovf_x ? 62'd0 : top_x;
		p2.rem_y = p2.ovf_y ? 62'd0 : top_y;
		p2.num_x = {st_s1.n_x[25:0], 16'd0};
		p2.num_y = {st_s1.n_y[25:0], 16'd0};
		p2.neg_x = st_s1.neg_x;
		p2.neg_y = st_s1.neg_y;
		p2.nz_x  = st_s1.nz_x;
		p2.nz_y  = st_s1.nz_y;
		p2.zdiv  = st_s1.zdiv;
		p2.p_x   = 49'(st_s1.x) + 49'(st_s1.sh_x >>> 16);
		p2.p_y   = 49'(st_s1.y) + 49'(st_s1.sh_y >>> 16);
	end

	always_ff @(posedge clk) begin
		if (adv) step_s[0] <= p2;
	end

	// ---------------------------------------------------------------
	// Divider: one restoring step per stage for both lanes. The parallel
	// term is scaled in the first two steps and then carried along.
	// ---------------------------------------------------------------
	function automatic dv_t div_step(dv_t a);
		dv_t         b;
		logic [62:0] rx, ry;
		b  = a;
		rx = {a.rem_x, a.num_x[41]};
		ry = {a.rem_y, a.num_y[41]};
		if (rx >= {1'b0, a.den}) begin
			b.rem_x = 62'(rx - {1'b0, a.den});
			b.quo_x = {a.quo_x[40:0], 1'b1};
		end else begin
			b.rem_x = rx[61:0];
			b.quo_x = {a.quo_x[40:0], 1'b0};
		end
		if (ry >= {1'b0, a.den}) begin
			b.rem_y = 62'(ry - {1'b0, a.den});
			b.quo_y = {a.quo_y[40:0], 1'b1};
		end else begin
			b.rem_y = ry[61:0];
			b.quo_y = {a.quo_y[40:0], 1'b0};
		end
		b.num_x = {a.num_x[40:0], 1'b0};
		b.num_y = {a.num_y[40:0], 1'b0};
		return b;
	endfunction

	logic signed [32:0] scx, nscy;
	assign scx  = 33'(scale_x_q);
	assign nscy = 33'sd0 - 33'(scale_y_q);

	for (genvar k = 1; k <= QBITS; k++) begin : g_step
		dv_t nxt;
		always_comb begin
			nxt = div_step(step_s[k-1]);
			if (k == 1) begin
				// split p * s into the high part p[48:16] and the low 16 bits to keep multipliers narrow
				nxt.par_x = $signed(step_s[k-1].p_x[48:16]) * scx;
				nxt.par_y = $signed(step_s[k-1].p_y[48:16]) * nscy;
				nxt.lo_x  = $signed({1'b0, step_s[k-1].p_x[15:0]}) * scx;
				nxt.lo_y  = $signed({1'b0, step_s[k-1].p_y[15:0]}) * nscy;
			end else if (k == 2) begin
				nxt.par_x = step_s[k-1].par_x + 67'(step_s[k-1].lo_x >>> 16);
				nxt.par_y = step_s[k-1].par_y + 67'(step_s[k-1].lo_y >>> 16);
			end
		end
		always_ff @(posedge clk) begin
			if (adv) step_s[k] <= nxt;
		end
	end

	// ---------------------------------------------------------------
	// Final stage: perspective term, mode select, center add, saturate
	// ---------------------------------------------------------------
	// The quotient is a truncated magnitude: round a negative term down by
	// one more step when the division left a remainder.
	function automatic logic signed [43:0] persp_term(logic [41:0] quo, logic [61:0] rem,
		logic big, logic nz, logic neg);
		logic [42:0] m;
		if (big) m = nz ? {1'b0, TERM_LIMIT} : 43'd0;
		else     m = {1'b0, quo} + 43'(neg && (rem != 62'd0));
		return neg ? 44'sd0 - $signed({1'b0, m}) : $signed({1'b0, m});
	endfunction

	dv_t                fin;
	logic               big_x, big_y, sat_x, sat_y, flag_f;
	logic signed [66:0] term_x, term_y;
	logic signed [67:0] sum_x, sum_y;
	logic signed [31:0] res_x, res_y;
	logic signed [31:0] sx_q, sy_q;
	logic               flag_q;

	always_comb begin
		fin   = step_s[QBITS];
		big_x = fin.zdiv || fin.ovf_x || (fin.quo_x > TERM_LIMIT);
		big_y = fin.zdiv || fin.ovf_y || (fin.quo_y > TERM_LIMIT);
		if (mode_q) begin
			term_x = 67'(persp_term(fin.quo_x, fin.rem_x, big_x, fin.nz_x, fin.neg_x));
			term_y = 67'(persp_term(fin.quo_y, fin.rem_y, big_y, fin.nz_y, fin.neg_y));
		end else begin
			term_x = fin.par_x;
			term_y = fin.par_y;
		end
		sum_x = 68'(center_x_q) + 68'(term_x);
		sum_y = 68'(center_y_q) + 68'(term_y);

		sat_x = 1'b1;
		priority if (sum_x > 68'sd2147483647)  res_x = 32'h7FFF_FFFF;
		else if (sum_x < -68'sd2147483648)      res_x = 32'h8000_0000;
		else begin
			res_x = sum_x[31:0];
			sat_x = 1'b0;
		end
		sat_y = 1'b1;
		priority if (sum_y > 68'sd2147483647)  res_y = 32'h7FFF_FFFF;
		else if (sum_y < -68'sd2147483648)      res_y = 32'h8000_0000;
		else begin
			res_y = sum_y[31:0];
			sat_y = 1'b0;
		end
		flag_f = (mode_q && fin.zdiv) || sat_x || sat_y;
	end

	// Output register: hold until the beat is taken
	always_ff @(posedge clk) begin
		if (adv) begin
			sx_q   <= res_x;
			sy_q   <= res_y;
			flag_q <= flag_f;
		end
	end

	assign screen.valid      = out_valid_q;
	assign screen.screen_x   = sx_q;
	assign screen.screen_y   = sy_q;
	assign screen.range_flag = flag_q;

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(screen.valid && !screen.ready) |-> !point.ready)
		else $error("input taken while output beat is stalled");

	a_accept_enters_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		(point.valid && point.ready) |=> v_s1)
		else $error("accepted point did not enter stage 1");

	a_zero_div_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && vld_s[QBITS] && mode_q && step_s[QBITS].zdiv) |=> screen.range_flag)
		else $error("zero perspective divisor did not raise range_flag");

endmodule

// File: test/ppu_tb_if.sv
// Testbench types for the point projection channels: the expected screen beat; the RTL interfaces are reused.
// Depends on nothing.
`timescale 1ns / 100ps
package ppu_tb_types;
	typedef struct packed {
		logic signed [31:0] sx;
		logic signed [31:0] sy;
		logic               flag;
	} screen_beat_t;
endpackage

// File: test/ppu_checker.sv
// Checker for the point projection unit: watches both channels, predicts each screen beat.
// Depends on ppu_pkg, ppu_tb_types and the two channel interfaces.
`timescale 1ns / 100ps
module ppu_checker
	import ppu_pkg::*;
	import ppu_tb_types::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	ppu_point_if        point,
	ppu_screen_if       screen,
	output int          errors,
	output int          pending
);
	localparam logic signed [127:0] LIM = 128'sd1 <<< 40;
	localparam logic signed [127:0] SMAX = 128'sd2147483647;
	localparam logic signed [127:0] SMIN = -128'sd2147483648;

	logic               persp;
	logic        [30:0] tanv;
	logic signed [31:0] slx, sly, scx, scy, cx, cy;
	screen_beat_t       expected_q[$];

	// Floor division of a signed numerator by a positive divisor.
	function automatic logic signed [127:0] fdiv(logic signed [127:0] n, logic signed [127:0] d);
		logic signed [127:0] q;
		q = n / d;
		if ((n % d) != 0 && n < 0) q = q - 1;
		return q;
	endfunction

	function automatic logic signed [127:0] persp_term(logic signed [127:0] a,
			logic signed [127:0] z);
		logic signed [127:0] num, den, q;
		num = a * cx * 65536;
		den = z * tanv;
		if (den < 0) begin
			num = -num;
			den = -den;
		end
		q = fdiv(num, den);
		if (q > LIM) q = LIM;
		if (q < -LIM) q = -LIM;
		return q;
	endfunction

	function automatic screen_beat_t project(logic signed [31:0] x, logic signed [31:0] y,
			logic signed [31:0] z);
		logic signed [127:0] tx, ty, px, py, vx, vy;
		screen_beat_t r;
		r.flag = 0;
		if (persp) begin
			if (z == 0 || tanv == 0) begin
				r.flag = 1;
				tx = (x == 0 || cx == 0) ? 0 : (((x < 0) != (cx < 0)) ? -LIM : LIM);
				ty = (y == 0 || cx == 0) ? 0 : (((y > 0) != (cx < 0)) ? -LIM : LIM);
			end else begin
				tx = persp_term(x, z);
				ty = persp_term(-128'(y), z);
			end
		end else begin
			px = x + fdiv(128'(slx) * z, 65536);
			py = y + fdiv(128'(sly) * z, 65536);
			tx = fdiv(px * scx, 65536);
			ty = fdiv(py * (-128'(scy)), 65536);
		end
		vx = cx + tx;
		vy = cy + ty;
		if (vx > SMAX) begin vx = SMAX; r.flag = 1; end
		if (vx < SMIN) begin vx = SMIN; r.flag = 1; end
		if (vy > SMAX) begin vy = SMAX; r.flag = 1; end
		if (vy < SMIN) begin vy = SMIN; r.flag = 1; end
		r.sx = vx[31:0];
		r.sy = vy[31:0];
		return r;
	endfunction

	assign pending = expected_q.size();

	always @(posedge clk or negedge arst_n) begin
		screen_beat_t e;
		if (!arst_n) begin
			persp <= 1;
			tanv <= 31'd65536;
			slx <= 0; sly <= 0; scx <= 65536; scy <= 65536; cx <= 0; cy <= 0;
			errors <= 0;
			expected_q.delete();
		end else begin
			if (point.valid && point.ready)
				expected_q.push_back(project(point.point_x, point.point_y, point.point_z));
			if (screen.valid && screen.ready) begin
				if (expected_q.size() == 0) begin
					if (errors < 10) $display("%0t: screen beat with nothing expected", $realtime);
					errors <= errors + 1;
				end else begin
					e = expected_q.pop_front();
					if (e.sx !== screen.screen_x || e.sy !== screen.screen_y
							|| e.flag !== screen.range_flag) begin
						if (errors < 10)
							$display("%0t: expected (%0d,%0d,%b) got (%0d,%0d,%b)", $realtime,
								e.sx, e.sy, e.flag, screen.screen_x, screen.screen_y,
								screen.range_flag);
						errors <= errors + 1;
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_MODE:     persp <= cfg_data[0];
					REG_TAN:      tanv <= cfg_data[30:0];
					REG_SLOPE_X:  slx <= cfg_data;
					REG_SLOPE_Y:  sly <= cfg_data;
					REG_SCALE_X:  scx <= cfg_data;
					REG_SCALE_Y:  scy <= cfg_data;
					REG_CENTER_X: cx <= cfg_data;
					REG_CENTER_Y: cy <= cfg_data;
					default: ;
				endcase
			end
		end
	end
endmodule

// File: test/tb_point_projection_unit.sv
// Top of the point projection unit testbench: clock, reset, stimulus and verdict.
// Depends on ppu_pkg, the channel interfaces, ppu_checker and point_projection_unit.
`timescale 1ns / 100ps
module tb_point_projection_unit;
	import ppu_pkg::*;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_we = 0;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;
	int          errors, pending;
	bit          busy_mode = 1;  // random idling on when set

	ppu_point_if  point ();
	ppu_screen_if screen ();

	point_projection_unit dut (.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.point(point.sink), .screen(screen.source));

	ppu_checker chk (.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.point(point), .screen(screen), .errors, .pending);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	initial begin
		point.valid = 0;
		point.point_x = 0;
		point.point_y = 0;
		point.point_z = 0;
		screen.ready = 0;
	end

	// Receiver: stall at random about 37 percent of the time, except in the quiet stretch.
	always @(posedge clk)
		screen.ready <= !busy_mode || ($urandom_range(99) >= 37);

	// Write one register; the block is idle whenever this is called.
	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		@(posedge clk);
	endtask

	// Present one point and hold it until the beat is taken; idle first at random.
	// Valid stays high afterwards so the next point can follow back to back.
	task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		while (busy_mode && $urandom_range(99) < 37) begin
			point.valid <= 0;
			@(posedge clk);
		end
		point.valid <= 1;
		point.point_x <= x;
		point.point_y <= y;
		point.point_z <= z;
		do @(posedge clk); while (!point.ready);
	endtask

	// Drain every expected beat, then let the pipe settle before touching registers.
	task automatic drain();
		point.valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	// Pick a coordinate: mostly moderate values, sometimes extremes or full range.
	function automatic logic [31:0] rand_coord();
		case ($urandom_range(9))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 0;
			3, 4: return $urandom;
			default: return $signed($urandom_range(32'h0200_0000)) - 32'sh0100_0000;
		endcase
	endfunction

	function automatic logic [31:0] rand_reg();
		case ($urandom_range(5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return $urandom;
			default: return $signed($urandom_range(32'h0004_0000)) - 32'sh0002_0000;
		endcase
	endfunction

	task automatic random_settings(bit persp);
		write_reg(REG_MODE, {31'd0, persp});
		write_reg(REG_TAN, ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h0003_0000));
		write_reg(REG_SLOPE_X, rand_reg());
		write_reg(REG_SLOPE_Y, rand_reg());
		write_reg(REG_SCALE_X, rand_reg());
		write_reg(REG_SCALE_Y, rand_reg());
		write_reg(REG_CENTER_X, rand_reg());
		write_reg(REG_CENTER_Y, rand_reg());
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: reset settings, zero depth, extremes and sign mixes in perspective.
		write_reg(REG_CENTER_X, 32'h0140_0000);
		write_reg(REG_CENTER_Y, 32'h00f0_0000);
		send_point(0, 0, 0);
		send_point(32'h0001_0000, 32'hffff_0000, 0);
		send_point(32'h0001_0000, 32'h0002_0000, 32'h0004_0000);
		send_point(32'hffff_0000, 32'h0002_0000, 32'hfffc_0000);
		send_point(32'h7fff_ffff, 32'h8000_0000, 1);
		send_point(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
		send_point(32'h0000_0003, 32'hffff_fffd, 32'h7fff_ffff);
		drain();
		// Zero tangent divides by zero, and a negative center flips the clamp.
		write_reg(REG_TAN, 0);
		write_reg(REG_CENTER_X, 32'h8000_0000);
		send_point(32'h0001_0000, 0, 32'h0001_0000);
		send_point(32'hffff_0000, 32'h0001_0000, 32'h0001_0000);
		drain();
		write_reg(REG_TAN, 32'h7fff_ffff);
		write_reg(REG_CENTER_X, 32'h7fff_ffff);
		send_point(32'h7fff_ffff, 32'h7fff_ffff, 1);
		send_point(5, 7, 32'h7fff_ffff);
		drain();
		// Parallel mode with shear, extremes of every scale.
		write_reg(REG_MODE, 0);
		write_reg(REG_SLOPE_X, 32'h0000_8000);
		write_reg(REG_SLOPE_Y, 32'h8000_0000);
		write_reg(REG_SCALE_X, 32'h8000_0000);
		write_reg(REG_SCALE_Y, 32'h7fff_ffff);
		write_reg(REG_CENTER_Y, 32'h8000_0000);
		send_point(0, 0, 0);
		send_point(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
		send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
		send_point(32'hffff_ffff, 1, 32'hffff_ffff);
		// Out-of-range index does not exist with a 3-bit index; all eight are covered.
		drain();

		// Random phases, alternating modes; one phase runs with no idling at all.
		for (int ph = 0; ph < 12; ph++) begin
			random_settings(ph[0]);
			busy_mode = (ph != 5);
			repeat (130) send_point(rand_coord(), rand_coord(), rand_coord());
			drain();
		end
		busy_mode = 1;

		if (errors == 0)
			$display("PASS point_projection_unit");
		else
			$display("FAIL point_projection_unit");
		$finish;
	end

	initial begin
		#5ms;
		$display("FAIL point_projection_unit");
		$finish;
	end
endmodule

// File: sim.f
rtl/ppu_pkg.sv
rtl/ppu_point_if.sv
rtl/ppu_screen_if.sv
rtl/point_projection_unit.sv
test/ppu_tb_if.sv
test/ppu_checker.sv
test/tb_point_projection_unit.sv
